// ===== rtl/csa_pkg.sv =====
// Shared types and constants for the cosine series approximator.
// Holds field widths, the term divisor function, the state and command enums
// and the controller/datapath structs. No dependencies.
package csa_pkg;

    // Series depth
    localparam int MAX_ORDER = 8;
    localparam int TERM_W    = $clog2(MAX_ORDER + 1);

    // Port fields
    localparam int ANGLE_W = 16;
    localparam int ORDER_W = 4;
    localparam int COS_W   = 32;

    // Datapath widths (sized for the largest term reachable at MAX_ORDER)
    localparam int AX_W    = ANGLE_W + 1;          // |angle|, up to 2^15
    localparam int XSQ_W   = 2 * ANGLE_W - 9;      // x^2 in Q8.16, up to 2^22
    localparam int MAG_W   = 42;                   // term magnitude, Q.32
    localparam int HALF_W  = MAG_W / 2;            // multiplier A operand
    localparam int PROD_W  = HALF_W + XSQ_W;       // multiplier output
    localparam int SUM_W   = 64;                   // full product plus rounding
    localparam int NUM_W   = SUM_W - 16;           // dividend after >> 16
    localparam int ACC_W   = MAG_W + 2;            // signed Q.32 accumulator
    localparam int D_W     = $clog2((2 * MAX_ORDER - 1) * (2 * MAX_ORDER) + 1);

    // Divider: bits retired per cycle and division steps per term
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Divisor (2i-1)*(2i) for term i
    function automatic logic [D_W-1:0] term_divisor(input logic [TERM_W-1:0] i);
        int v;
        v = (2 * int'(i) - 1) * (2 * int'(i));
        return D_W'(v);
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROUND,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_DIV,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_SQUARE,
        CMD_ROUND,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_MUL_SUM,
        CMD_DIV,
        CMD_ACCUM,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [TERM_W-1:0]   term;
    } csa_cmd_t;

    typedef struct packed {
        logic out_free;
    } csa_status_t;

endpackage

// ===== rtl/csa_ctrl.sv =====
// Sequencing state machine for the cosine series approximator.
// Tracks order, term index and divider steps; drives commands to csa_dpath.
// Depends on csa_pkg.
module csa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic [csa_pkg::ORDER_W-1:0] order,
    output logic                 s_tready,
    input  csa_pkg::csa_status_t status,
    output csa_pkg::csa_cmd_t    cmd
);

    csa_pkg::state_t              state_reg, state_next;
    logic [csa_pkg::TERM_W-1:0]    n_reg, n_next;
    logic [csa_pkg::TERM_W-1:0]    term_reg, term_next;
    logic [csa_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= csa_pkg::ST_IDLE;
            n_reg       <= '0;
            term_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            term_reg    <= term_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state and counters
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        term_next    = term_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            csa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // clamp order to the deepest supported term
                    if (int'(order) > csa_pkg::MAX_ORDER)
                        n_next = csa_pkg::TERM_W'(csa_pkg::MAX_ORDER);
                    else
                        n_next = csa_pkg::TERM_W'(order);
                    term_next  = csa_pkg::TERM_W'(1);
                    state_next = csa_pkg::ST_SQUARE;
                end
            end
            csa_pkg::ST_SQUARE:
                state_next = csa_pkg::ST_ROUND;
            csa_pkg::ST_ROUND:
            begin
                if (n_reg == '0)
                    state_next = csa_pkg::ST_FINISH;
                else
                    state_next = csa_pkg::ST_MUL_LO;
            end
            csa_pkg::ST_MUL_LO:
                state_next = csa_pkg::ST_MUL_HI;
            csa_pkg::ST_MUL_HI:
                state_next = csa_pkg::ST_MUL_SUM;
            csa_pkg::ST_MUL_SUM:
            begin
                div_cnt_next = '0;
                state_next   = csa_pkg::ST_DIV;
            end
            csa_pkg::ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == csa_pkg::DIV_CNT_W'(csa_pkg::DIV_STEPS - 1))
                    state_next = csa_pkg::ST_ACCUM;
            end
            csa_pkg::ST_ACCUM:
            begin
                term_next = term_reg + 1'b1;
                if (term_reg == n_reg)
                    state_next = csa_pkg::ST_FINISH;
                else
                    state_next = csa_pkg::ST_MUL_LO;
            end
            csa_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    state_next = csa_pkg::ST_IDLE;
            end
            default:
                state_next = csa_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = 1'b0;
        cmd.op   = csa_pkg::CMD_NOP;
        cmd.term = term_reg;
        unique case (state_reg)
            csa_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    cmd.op = csa_pkg::CMD_LOAD;
            end
            csa_pkg::ST_SQUARE:  cmd.op = csa_pkg::CMD_SQUARE;
            csa_pkg::ST_ROUND:   cmd.op = csa_pkg::CMD_ROUND;
            csa_pkg::ST_MUL_LO:  cmd.op = csa_pkg::CMD_MUL_LO;
            csa_pkg::ST_MUL_HI:  cmd.op = csa_pkg::CMD_MUL_HI;
            csa_pkg::ST_MUL_SUM: cmd.op = csa_pkg::CMD_MUL_SUM;
            csa_pkg::ST_DIV:     cmd.op = csa_pkg::CMD_DIV;
            csa_pkg::ST_ACCUM:   cmd.op = csa_pkg::CMD_ACCUM;
            csa_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    cmd.op = csa_pkg::CMD_EMIT;
            end
            default:
                cmd.op = csa_pkg::CMD_NOP;
        endcase
    end

endmodule

// ===== rtl/csa_dpath.sv =====
// Datapath for the cosine series approximator: shared multiplier, constant
// divisor long divider, term accumulator and output register.
// Depends on csa_pkg; driven by csa_ctrl.
module csa_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  csa_pkg::csa_cmd_t             cmd,
    output csa_pkg::csa_status_t          status,
    input  logic [csa_pkg::ANGLE_W-1:0]   angle,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csa_pkg::COS_W-1:0]     cosine,
    output logic                          saturated
);

    logic [csa_pkg::AX_W-1:0]   ax_reg, ax_next;
    logic [csa_pkg::XSQ_W-1:0]  xsq_reg, xsq_next;
    logic [csa_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [csa_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [csa_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [csa_pkg::D_W-1:0]    rem_reg, rem_next;
    logic [csa_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic signed [csa_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [csa_pkg::COS_W-1:0]  cos_reg, cos_next;
    logic                       sat_reg, sat_next;
    logic                       out_valid_reg, out_valid_next;

    logic [csa_pkg::HALF_W-1:0] mul_a;
    logic [csa_pkg::XSQ_W-1:0]  mul_b;
    logic [csa_pkg::D_W-1:0]    div_d;
    logic [csa_pkg::SUM_W-1:0]  full_sum;
    logic [csa_pkg::D_W-1:0]    div_rem;
    logic [csa_pkg::DIV_BITS-1:0] div_q;
    logic signed [csa_pkg::ACC_W:0] rnd_acc;
    logic [csa_pkg::COS_W:0]    rnd_q;
    logic [csa_pkg::ACC_W-1:0]  mag_ext;

    assign div_d   = csa_pkg::term_divisor(cmd.term);
    assign mag_ext = {{(csa_pkg::ACC_W - csa_pkg::MAG_W){1'b0}},
                      num_reg[csa_pkg::MAG_W-1:0]};

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.op)
            csa_pkg::CMD_SQUARE:
            begin
                mul_a = csa_pkg::HALF_W'(ax_reg);
                mul_b = csa_pkg::XSQ_W'(ax_reg);
            end
            csa_pkg::CMD_MUL_HI:
            begin
                mul_a = mag_reg[csa_pkg::MAG_W-1:csa_pkg::HALF_W];
                mul_b = xsq_reg;
            end
            default:
            begin
                mul_a = mag_reg[csa_pkg::HALF_W-1:0];
                mul_b = xsq_reg;
            end
        endcase
    end

    // Upper partial product lands 21 bits up; truncation to 64 bits is safe
    assign full_sum = sum_reg + {prod_reg[csa_pkg::SUM_W-csa_pkg::HALF_W-1:0],
                                 {csa_pkg::HALF_W{1'b0}}};

    // Restoring division, DIV_BITS quotient bits per cycle, MSB first
    always_comb
    begin
        logic [csa_pkg::D_W:0]   t;
        logic [csa_pkg::D_W-1:0] r;
        r = rem_reg;
        div_q = '0;
        for (int k = 0; k < csa_pkg::DIV_BITS; k++)
        begin
            t = {r, num_reg[csa_pkg::NUM_W-1-k]};
            if (t >= {1'b0, div_d})
            begin
                t = t - {1'b0, div_d};
                div_q[csa_pkg::DIV_BITS-1-k] = 1'b1;
            end
            r = t[csa_pkg::D_W-1:0];
        end
        div_rem = r;
    end

    // Round accumulator to Q12.20 and clamp
    assign rnd_acc = {acc_reg[csa_pkg::ACC_W-1], acc_reg} + (csa_pkg::ACC_W+1)'(2048);
    assign rnd_q   = rnd_acc[csa_pkg::ACC_W:12];

    always_comb
    begin
        ax_next        = ax_reg;
        xsq_next       = xsq_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        mag_next       = mag_reg;
        acc_next       = acc_reg;
        cos_next       = cos_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (cmd.op)
            csa_pkg::CMD_LOAD:
            begin
                if (angle[csa_pkg::ANGLE_W-1])
                    ax_next = csa_pkg::AX_W'(0) - {angle[csa_pkg::ANGLE_W-1], angle};
                else
                    ax_next = {1'b0, angle};
                mag_next = csa_pkg::MAG_W'(64'd1 << 32);
                acc_next = csa_pkg::ACC_W'(64'd1 << 32);
            end
            csa_pkg::CMD_SQUARE:
                prod_next = mul_a * mul_b;
            csa_pkg::CMD_ROUND:
                xsq_next = csa_pkg::XSQ_W'((prod_reg[2*csa_pkg::AX_W-4:0]
                                            + (2*csa_pkg::AX_W-3)'(128)) >> 8);
            csa_pkg::CMD_MUL_LO:
                prod_next = mul_a * mul_b;
            csa_pkg::CMD_MUL_HI:
            begin
                sum_next  = csa_pkg::SUM_W'(prod_reg)
                          + (csa_pkg::SUM_W'(div_d) << 15);
                prod_next = mul_a * mul_b;
            end
            csa_pkg::CMD_MUL_SUM:
            begin
                num_next = full_sum[csa_pkg::SUM_W-1:16];
                rem_next = '0;
            end
            csa_pkg::CMD_DIV:
            begin
                num_next = {num_reg[csa_pkg::NUM_W-csa_pkg::DIV_BITS-1:0], div_q};
                rem_next = div_rem;
            end
            csa_pkg::CMD_ACCUM:
            begin
                mag_next = num_reg[csa_pkg::MAG_W-1:0];
                if (cmd.term[0])
                    acc_next = acc_reg - signed'(mag_ext);
                else
                    acc_next = acc_reg + signed'(mag_ext);
            end
            csa_pkg::CMD_EMIT:
            begin
                out_valid_next = 1'b1;
                sat_next       = rnd_q[csa_pkg::COS_W] ^ rnd_q[csa_pkg::COS_W-1];
                if (rnd_q[csa_pkg::COS_W] ^ rnd_q[csa_pkg::COS_W-1])
                    cos_next = rnd_q[csa_pkg::COS_W]
                             ? {1'b1, {(csa_pkg::COS_W-1){1'b0}}}
                             : {1'b0, {(csa_pkg::COS_W-1){1'b1}}};
                else
                    cos_next = rnd_q[csa_pkg::COS_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        xsq_reg  <= xsq_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
        cos_reg  <= cos_next;
        sat_reg  <= sat_next;
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign cosine    = cos_reg;
    assign saturated = sat_reg;

endmodule

// ===== rtl/cosine_series_approximator.sv =====
// Cosine Maclaurin series approximator, top level. Uses csa_pkg, csa_ctrl, csa_dpath.
// Takes a new item only in idle, after the last one has reached the output register;
// each term takes two passes of the shared 21x23 multiplier, a summing step, the
// 8-bit-per-cycle divider and one add.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n, async, active low) clears controller state and the output valid flag.
module cosine_series_approximator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] angle (Q4.12), [19:16] order, [23:20] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] cosine (Q12.20)
    output logic        m_tuser     // [0] saturated
);

    csa_pkg::csa_cmd_t    cmd;
    csa_pkg::csa_status_t status;

    // Sequencer: owns the order, the term index and the divider step count
    csa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .order    (s_tdata[csa_pkg::ANGLE_W +: csa_pkg::ORDER_W]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic: squares the angle, steps each term and holds the result
    csa_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .angle     (s_tdata[csa_pkg::ANGLE_W-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cosine    (m_tdata),
        .saturated (m_tuser)
    );

`ifndef SYNTHESIS
    // The block goes busy right after taking an item
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a computation was starting");

    // A transfer always starts with the squaring step
    a_square_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (cmd.op == csa_pkg::CMD_SQUARE))
        else $error("squaring step did not follow input transfer");

    // Never overwrite a result that is still waiting
    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == csa_pkg::CMD_EMIT) |-> status.out_free)
        else $error("result emitted over a pending output");

    // An emitted result shows up on the output
    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == csa_pkg::CMD_EMIT) |=> m_tvalid)
        else $error("emitted result not presented");
`endif

endmodule

// ===== tb/tb_cosine_series_approximator.sv =====
// Self-checking testbench for cosine_series_approximator.
// Depends on csa_pkg (MAX_ORDER) and the block's RTL; predicts each Q12.20 sum with
// its own 64-bit model of the term recurrence and checks every output transfer in order.
module tb_cosine_series_approximator;

    // One predicted output transfer, tagged with the input that caused it
    typedef struct {
        logic [15:0] angle;
        logic [3:0]  order;
        logic [31:0] cosine;
        logic        saturated;
    } cos_result_t;

    // Scoreboard: predicts the partial sum for each accepted input and holds it
    // until the matching output transfer arrives.
    class cosine_scoreboard;
        cos_result_t cos_expected[$];
        int          mismatches;
        int          checked;
        int          accepted;

        function new();
            mismatches = 0;
            checked    = 0;
            accepted   = 0;
        endfunction

        // Predict the Maclaurin partial sum for one accepted input transfer.
        function void note_angle(logic [15:0] angle, logic [3:0] order);
            longint signed xs;
            longint signed acc;
            longint signed rnd;
            logic [63:0]   ax;
            logic [63:0]   xsq;
            logic [63:0]   mag;
            logic [63:0]   d;
            int            n;
            cos_result_t   e;
            xs  = longint'($signed(angle));
            ax  = (xs < 0) ? 64'(-xs) : 64'(xs);
            // x^2 exact in Q8.24, rounded to Q8.16
            xsq = (ax * ax + 64'd128) >> 8;
            n   = (int'(order) > csa_pkg::MAX_ORDER) ? csa_pkg::MAX_ORDER : int'(order);
            mag = 64'd1 << 32;
            acc = longint'(64'd1 << 32);
            for (int i = 1; i <= n; i++)
            begin
                d   = 64'((2 * i - 1) * (2 * i));
                // round to nearest, halves up
                mag = (mag * xsq + (d << 15)) / (d << 16);
                if (i % 2 == 1)
                    acc = acc - longint'(mag);
                else
                    acc = acc + longint'(mag);
            end
            // Q.32 to Q12.20, round to nearest, halves up
            rnd = (acc + 64'sd2048) >>> 12;
            e.angle     = angle;
            e.order     = order;
            e.saturated = 1'b0;
            if (rnd > 64'sd2147483647)
            begin
                rnd         = 64'sd2147483647;
                e.saturated = 1'b1;
            end
            else if (rnd < -64'sd2147483648)
            begin
                rnd         = -64'sd2147483648;
                e.saturated = 1'b1;
            end
            e.cosine = rnd[31:0];
            cos_expected.push_back(e);
            accepted++;
        endfunction

        // Compare one output transfer against the oldest prediction.
        function void check_cosine(logic [31:0] cosine, logic saturated);
            cos_result_t e;
            if (cos_expected.size() == 0)
            begin
                $display("%0t: unexpected output transfer cosine=%h saturated=%b",
                         $time, cosine, saturated);
                mismatches++;
                return;
            end
            e = cos_expected.pop_front();
            checked++;
            if (cosine !== e.cosine)
            begin
                $display("%0t: cosine mismatch (angle=%h order=%0d) expected %h actual %h",
                         $time, e.angle, e.order, e.cosine, cosine);
                mismatches++;
            end
            if (saturated !== e.saturated)
            begin
                $display("%0t: saturated mismatch (angle=%h order=%0d) expected %b actual %b",
                         $time, e.angle, e.order, e.saturated, saturated);
                mismatches++;
            end
        endfunction

        function int pending();
            return cos_expected.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // [15:0] angle, [19:16] order, [23:20] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] cosine
    logic        m_tuser;     // [0] saturated

    cosine_scoreboard sb;

    // Idle controls for each side, and a request for a long output hold-off
    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold_req;
    int clamp_items;

    cosine_series_approximator uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10-unit clock period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item and hold it until the block takes the transfer.
    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_angle(input logic [15:0] angle, input logic [3:0] order);
        while (tx_idle_en && ($urandom_range(0, 99) < 38))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, order, angle};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_angle(angle, order);
        if (int'(order) > csa_pkg::MAX_ORDER)
            clamp_items++;
        @(negedge clk);
    endtask

    // Draw a random item: mostly in-range orders, some above MAX_ORDER to hit the clamp;
    // angles are either full-range or confined to one period either side of zero.
    task automatic send_random_angle();
        logic [15:0] a;
        logic [3:0]  o;
        if ($urandom_range(0, 99) < 65)
            a = 16'($urandom);
        else
        begin
            a = 16'($urandom_range(0, 25736));
            if ($urandom_range(0, 1) == 1)
                a = -a;
        end
        if ($urandom_range(0, 99) < 80)
            o = 4'($urandom_range(0, csa_pkg::MAX_ORDER));
        else
            o = 4'($urandom_range(csa_pkg::MAX_ORDER + 1, 15));
        send_angle(a, o);
    endtask

    // Check every output transfer at the rising edge that completes it
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_cosine(m_tdata, m_tuser);
    end

    // Receiver: change tready at falling edges; on request, hold off for a long
    // stretch so the output register fills and the block stalls its input.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            m_tready <= !(rx_idle_en && ($urandom_range(0, 99) < 38));
        end
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #6000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = 1'b0;
        clamp_items = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, order zero, clamp, most negative angle, known angles
        send_angle(16'h0000, 4'd0);
        send_angle(16'h0000, 4'd8);
        send_angle(16'h7FFF, 4'd0);
        send_angle(16'h7FFF, 4'd8);
        send_angle(16'h7FFF, 4'd15);
        send_angle(16'h8000, 4'd0);
        send_angle(16'h8000, 4'd1);
        send_angle(16'h8000, 4'd8);
        send_angle(16'h8000, 4'd15);
        send_angle(16'h8001, 4'd9);
        send_angle(16'h0001, 4'd8);
        send_angle(16'hFFFF, 4'd8);
        send_angle(16'h1000, 4'd1);    // 1.0
        send_angle(16'h1000, 4'd4);
        send_angle(16'hF000, 4'd4);    // -1.0
        send_angle(16'h3244, 4'd8);    // about pi
        send_angle(16'hCDBC, 4'd8);    // about -pi
        send_angle(16'h6488, 4'd8);    // about 2*pi
        send_angle(16'h1922, 4'd2);    // about pi/2
        send_angle(16'h0080, 4'd3);    // tiny angle, third term underflows to zero
        send_angle(16'h0010, 4'd8);
        send_angle(16'h5555, 4'd5);
        send_angle(16'hAAAA, 4'd6);
        send_angle(16'h4000, 4'd7);

        // Random with idling on both sides
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (250) send_random_angle();

        // Long stretch with no idling at all
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (150) send_random_angle();

        // Hold off the receiver while the sender keeps offering back to back
        rx_hold_req = 1'b1;
        repeat (50) send_random_angle();

        // Random again with idling on both sides
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (300) send_random_angle();
        s_tvalid <= 1'b0;

        // Drain: wait for every prediction to be matched, then let the block settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d input transfers (%0d with clamped order) and %0d checked results,",
                 sb.accepted, clamp_items, sb.checked);
        $display("with random idling, a no-idle burst and a 400-cycle output hold-off");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
